[src/sne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sne_pkg
// Shared types, character constants and the character mapping function for
// the 8.3 short name encoder.
// ----------------------------------------------------------------------------
package sne_pkg;

  // character codes
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_DELETED    = 8'hE5;
  localparam logic [7:0] CHAR_KANJI_LEAD = 8'h05;

  // padded field values
  localparam logic [63:0] SPACE8   = 64'h2020_2020_2020_2020;
  localparam logic [23:0] SPACE3   = 24'h20_2020;
  localparam logic [63:0] DOT_ONE  = 64'h2E20_2020_2020_2020;
  localparam logic [63:0] DOT_TWO  = 64'h2E2E_2020_2020_2020;

  localparam int unsigned BASE_LEN = 8;
  localparam int unsigned EXT_LEN  = 3;

  // one finished short name
  typedef struct packed {
    logic [63:0] base_part;
    logic [23:0] extension_part;
  } sne_result_t;

  // uppercase, replace anything outside the 8.3 set, then the 0xE5 rule
  function automatic logic [7:0] sne_map_char(input logic [7:0] c);
    logic [7:0] u;
    logic       ok;
    u = c;
    if (u >= 8'h61 && u <= 8'h7A) begin
      u = u - 8'h20;
    end
    ok = 1'b0;
    if (u >= 8'h41 && u <= 8'h5A) begin
      ok = 1'b1;
    end else if (u >= 8'h30 && u <= 8'h39) begin
      ok = 1'b1;
    end else begin
      case (u) inside
        8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
        8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    if (!ok) begin
      u = CHAR_UNDERSCORE;
    end
    if (u == CHAR_DELETED) begin
      u = CHAR_KANJI_LEAD;
    end
    return u;
  endfunction

endpackage

[src/sne_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sne_if
// Valid/ready channels of the encoder: name bytes in, short names out.
// ----------------------------------------------------------------------------
interface sne_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       name_end;

  modport source (output valid, output name_byte, output name_end, input ready);
  modport sink   (input valid, input name_byte, input name_end, output ready);
endinterface

interface sne_short_if;
  logic        valid;
  logic        ready;
  logic [63:0] base_part;
  logic [23:0] extension_part;

  modport source (output valid, output base_part, output extension_part, input ready);
  modport sink   (input valid, input base_part, input extension_part, output ready);
endinterface

[src/short_name_8_3_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_name_8_3_encoder
// Builds the 11-byte space-padded 8.3 short name from a long name that
// arrives one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   name_in   carries one long-name byte per word, name_end set on the last.
//   short_out carries one word per name: base_part (8 bytes) and
//             extension_part (3 bytes), first character in the top byte.
//   One name byte is taken every cycle while ready is high; the per-byte
//   state update is one pass of mapping and lane-select logic ahead of the
//   state registers. The short name is registered in the output register,
//   or in the skid slot while the receiver stalls, before short_out shows it.
//   When the receiver stalls, the pending name holds on short_out and one
//   more finished name fits in a skid slot; name_in drops ready only while
//   that slot is occupied. Bytes that do not end a name are taken as usual
//   until then.
//   Reset (rst, synchronous) clears the name state and empties the output
//   register and the skid slot; after each name the state returns to its
//   reset values for the next one.
// ----------------------------------------------------------------------------
module short_name_8_3_encoder (
  input  logic       clk,
  input  logic       rst,
  sne_name_if.sink   name_in,
  sne_short_if.source short_out
);
  import sne_pkg::*;

  logic        accept;
  logic        res_push;
  sne_result_t res;
  logic        buf_full;

  assign name_in.ready = !buf_full;
  assign accept        = name_in.valid && name_in.ready;

  // name state and short name assembly
  sne_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .name_byte (name_in.name_byte),
    .name_end  (name_in.name_end),
    .res_push  (res_push),
    .res       (res)
  );

  // result register and skid slot
  sne_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .short_out (short_out)
  );

endmodule

[src/sne_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sne_accum
// Per-name state: phase, base and extension stores and dot tracking. Updated
// on every accepted word; produces the finished short name on the last word.
// ----------------------------------------------------------------------------
module sne_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           name_byte,
  input  logic                 name_end,
  output logic                 res_push,
  output sne_pkg::sne_result_t res
);
  import sne_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_BASE = 2'd1,
    PH_EXT  = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] base_store, base_store_next;
  logic [3:0]  base_taken, base_taken_next;
  logic [23:0] extension_store, extension_store_next;
  logic [1:0]  extension_taken, extension_taken_next;
  logic [1:0]  dots_only_length, dots_only_length_next;
  logic        only_dots_seen, only_dots_seen_next;

  logic        is_dot;
  logic        is_space;
  logic [7:0]  mapped;
  logic        base_put;
  logic        ext_put;
  logic        ext_clear;
  logic [63:0] b;
  logic [23:0] e;

  // next state for one word
  always_comb begin
    phase_next            = phase;
    base_store_next       = base_store;
    base_taken_next       = base_taken;
    extension_store_next  = extension_store;
    extension_taken_next  = extension_taken;
    dots_only_length_next = dots_only_length;
    only_dots_seen_next   = only_dots_seen;
    base_put              = 1'b0;
    ext_put               = 1'b0;
    ext_clear             = 1'b0;

    is_dot   = (name_byte == CHAR_DOT);
    is_space = (name_byte == CHAR_SPACE);
    mapped   = sne_map_char(name_byte);

    // dot-only names
    if (only_dots_seen && is_dot) begin
      if (dots_only_length != 2'd3) begin
        dots_only_length_next = dots_only_length + 2'd1;
      end
    end else begin
      only_dots_seen_next = 1'b0;
    end

    // phase handling
    case (phase)
      PH_SKIP: begin
        if (!is_dot && !is_space) begin
          phase_next = PH_BASE;
          base_put   = 1'b1;
        end
      end
      PH_BASE: begin
        if (is_dot) begin
          phase_next = PH_EXT;
          ext_clear  = 1'b1;
        end else if (!is_space) begin
          base_put = 1'b1;
        end
      end
      default: begin
        if (is_dot) begin
          ext_clear = 1'b1;
        end else if (!is_space) begin
          ext_put = 1'b1;
        end
      end
    endcase

    // base byte lanes, first character at the top
    if (base_put && !base_taken[3]) begin
      for (int i = 0; i < BASE_LEN; i++) begin
        if (base_taken[2:0] == 3'(i)) begin
          base_store_next[(BASE_LEN - 1 - i) * 8 +: 8] = mapped;
        end
      end
      base_taken_next = base_taken + 4'd1;
    end

    // extension byte lanes
    if (ext_clear) begin
      extension_store_next = SPACE3;
      extension_taken_next = 2'd0;
    end else if (ext_put && extension_taken != 2'd3) begin
      for (int i = 0; i < EXT_LEN; i++) begin
        if (extension_taken == 2'(i)) begin
          extension_store_next[(EXT_LEN - 1 - i) * 8 +: 8] = mapped;
        end
      end
      extension_taken_next = extension_taken + 2'd1;
    end
  end

  // finished name from the updated state
  always_comb begin
    b = base_store_next;
    e = extension_store_next;
    if (only_dots_seen_next &&
        (dots_only_length_next == 2'd1 || dots_only_length_next == 2'd2)) begin
      b = (dots_only_length_next == 2'd1) ? DOT_ONE : DOT_TWO;
      e = SPACE3;
    end else if (b[63:56] == CHAR_SPACE && e[23:16] == CHAR_SPACE) begin
      b[63:56] = CHAR_UNDERSCORE;
    end
  end

  assign res_push           = accept && name_end;
  assign res.base_part      = b;
  assign res.extension_part = e;

  // state registers, cleared again after each name
  always_ff @(posedge clk) begin
    if (rst || (accept && name_end)) begin
      phase            <= PH_SKIP;
      base_store       <= SPACE8;
      base_taken       <= 4'd0;
      extension_store  <= SPACE3;
      extension_taken  <= 2'd0;
      dots_only_length <= 2'd0;
      only_dots_seen   <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      base_store       <= base_store_next;
      base_taken       <= base_taken_next;
      extension_store  <= extension_store_next;
      extension_taken  <= extension_taken_next;
      dots_only_length <= dots_only_length_next;
      only_dots_seen   <= only_dots_seen_next;
    end
  end

endmodule

[src/sne_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sne_out_buf
// Result register with one skid slot, so input words keep flowing while a
// short name waits for the receiver.
// ----------------------------------------------------------------------------
module sne_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sne_pkg::sne_result_t push_data,
  output logic                 full,
  sne_short_if.source          short_out
);
  import sne_pkg::*;

  logic        out_valid;
  sne_result_t out_data;
  logic        skid_valid;
  sne_result_t skid_data;
  logic        pop;

  assign pop  = out_valid && short_out.ready;
  assign full = skid_valid;

  assign short_out.valid          = out_valid;
  assign short_out.base_part      = out_data.base_part;
  assign short_out.extension_part = out_data.extension_part;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if ((pop || !out_valid) && push) begin
      out_data <= push_data;
    end else if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule
